// ----- hdl/fault_line_heightmap_top_assert.svh -----
// Assertion macros shared by the heightmap RTL.
// Needs nothing but the including module's clock and reset names.
`ifndef FAULT_LINE_HEIGHTMAP_TOP_ASSERT_SVH
`define FAULT_LINE_HEIGHTMAP_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define FLH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define FLH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- hdl/flh_pkg.sv -----
// Package for the fault-line heightmap: sizes, operation codes, register indexes
// and mode constants. No dependencies.
package flh_pkg;
    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 256;
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int ADDR_W = COL_W + ROW_W;
    localparam int DIM_W = 9;
    localparam int HGT_W = 24;
    localparam int STEP_W = 16;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_FAULT = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    localparam logic signed [STEP_W-1:0] SMAX_MTN   = 16'sd1311;
    localparam logic signed [STEP_W-1:0] SMAX_PLAIN = 16'sd3277;
    localparam logic signed [STEP_W-1:0] SDEL_MTN   = -16'sd164;
    localparam logic signed [STEP_W-1:0] SDEL_PLAIN = -16'sd328;
    localparam logic signed [HGT_W-1:0] START_MTN   = 24'sd39322;
    localparam logic signed [HGT_W-1:0] START_PLAIN = 24'sd32768;
    localparam logic signed [HGT_W-1:0] H_MAX = 24'sh7FFFFF;
    localparam logic signed [HGT_W-1:0] H_MIN = 24'sh800000;
endpackage

// ----- hdl/flh_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module flh_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/flh_div.sv -----
// Restoring divider: 16-bit quotient of (num << 16) / den, one bit a cycle.
// Uses flh_pkg for widths.
module flh_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [flh_pkg::HGT_W:0]    i_num,
    input  logic [flh_pkg::HGT_W:0]    i_den,
    output logic                       o_done,
    output logic [15:0]                o_quot
);
    import flh_pkg::*;

    logic [HGT_W+1:0] r_rem, n_rem;
    logic [HGT_W:0]   r_den;
    logic [16:0]      r_q, n_q;
    logic [4:0]       r_cnt;
    logic             r_busy, r_done;
    logic [HGT_W+2:0] w_sh;
    logic [HGT_W+2:0] w_diff;

    // One restoring step: double the remainder and take the divisor off when it fits.
    always_comb begin
        w_sh   = {r_rem, 1'b0};
        w_diff = w_sh - {2'b00, r_den};
        if (!w_diff[HGT_W+2]) begin
            n_rem = w_diff[HGT_W+1:0];
            n_q   = {r_q[15:0], 1'b1};
        end else begin
            n_rem = w_sh[HGT_W+1:0];
            n_q   = {r_q[15:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_q    <= '0;
            // First quotient bit: num*65536/den >= 65536 when num >= den.
            if (i_num >= i_den) begin
                r_rem <= {1'b0, i_num - i_den};
                r_q   <= 17'd1;
            end else begin
                r_rem <= {1'b0, i_num};
            end
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q[16] ? 16'hFFFF : r_q[15:0];

    `include "fault_line_heightmap_top_assert.svh"
    `FLH_ASSERT_NXT(a_div_done, r_busy && r_cnt == 5'd15 && !i_start, r_done)
    `FLH_ASSERT_IMP(a_div_cnt, r_busy, r_cnt <= 5'd15)
    `FLH_ASSERT_NXT(a_div_idle, r_done, !r_busy || $past(i_start))
endmodule

// ----- hdl/flh_ctrl.sv -----
// Sequencer for the heightmap: sweeps the cell RAM for clear and fault items,
// tracks min and max, and drives the divider for reads. Uses flh_pkg, flh_ram, flh_div.
module flh_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [1:0]                        i_op,
    input  logic signed [15:0]                i_dir_cos,
    input  logic signed [15:0]                i_dir_sin,
    input  logic signed [14:0]                i_line_offset,
    input  logic [7:0]                        i_cell_col,
    input  logic [7:0]                        i_cell_row,
    input  logic                              i_mode,
    input  logic [flh_pkg::DIM_W-1:0]         i_w,
    input  logic [flh_pkg::DIM_W-1:0]         i_h,
    output logic                              o_done,
    output logic [15:0]                       o_norm,
    output logic                              o_flat
);
    import flh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CLEAR, S_FAULT, S_DRAIN, S_RDWAIT, S_DIV, S_DONE
    } t_state;

    t_state r_state;
    logic [COL_W:0] r_col;
    logic [ROW_W:0] r_row;
    logic [ADDR_W:0] r_clr;
    logic signed [STEP_W-1:0] r_step;
    logic signed [HGT_W-1:0] r_min, r_max, r_lo, r_hi;
    logic signed [15:0] r_a, r_b;
    logic signed [14:0] r_off;
    logic signed [31:0] r_rowterm, r_colterm;
    // pipeline: stage 1 = read issued, stage 2 = data back with side
    logic r_v1, r_v2;
    logic [ADDR_W-1:0] r_a1, r_a2;
    logic r_pos1, r_pos2;
    logic signed [HGT_W-1:0] r_d2;
    logic [ADDR_W-1:0] r_raddr;
    logic [15:0] r_norm;
    logic r_flat, r_done, r_dstart;
    logic [HGT_W:0] r_num, r_den;

    logic [COL_W:0] w_wc;
    logic [ROW_W:0] w_hc;
    logic [ADDR_W-1:0] w_raddr, w_waddr;
    logic [HGT_W-1:0] w_rdata, w_wdata;
    logic w_we;
    logic signed [HGT_W+1:0] w_sum;
    logic signed [HGT_W-1:0] w_new;
    logic signed [32:0] w_side;
    logic signed [STEP_W-1:0] w_smax, w_sdel;
    logic signed [HGT_W-1:0] w_start;
    logic signed [STEP_W:0] w_nstep;
    logic w_ddone;
    logic [15:0] w_quot;
    logic signed [HGT_W:0] w_numr;

    always_comb begin
        w_wc = (i_w == '0) ? (COL_W+1)'(1) :
               (i_w > DIM_W'(MAX_COLS)) ? (COL_W+1)'(MAX_COLS) : i_w[COL_W:0];
        w_hc = (i_h == '0) ? (ROW_W+1)'(1) :
               (i_h > DIM_W'(MAX_ROWS)) ? (ROW_W+1)'(MAX_ROWS) : i_h[ROW_W:0];
        w_smax  = i_mode ? SMAX_MTN : SMAX_PLAIN;
        w_sdel  = i_mode ? SDEL_MTN : SDEL_PLAIN;
        w_start = i_mode ? START_MTN : START_PLAIN;
        w_side  = 33'(r_rowterm) + 33'(r_colterm) + 33'($signed({r_off, 8'd0}));
        w_sum   = (HGT_W+2)'(r_d2) +
                  (r_pos2 ? (HGT_W+2)'(r_step) : -(HGT_W+2)'(r_step));
        w_new   = (w_sum > (HGT_W+2)'(H_MAX)) ? H_MAX :
                  (w_sum < (HGT_W+2)'(H_MIN)) ? H_MIN : w_sum[HGT_W-1:0];
        w_nstep = 17'(r_step) + 17'(w_sdel);
        w_numr  = (HGT_W+1)'($signed(w_rdata)) - (HGT_W+1)'(r_min);
        w_raddr = (r_state == S_FAULT) ? {r_row[ROW_W-1:0], r_col[COL_W-1:0]}
                                       : r_raddr;
        if (r_state == S_CLEAR) begin
            w_we = 1'b1; w_waddr = r_clr[ADDR_W-1:0]; w_wdata = w_start;
        end else begin
            w_we = r_v2; w_waddr = r_a2; w_wdata = w_new;
        end
    end

    flh_ram #(.WIDTH(HGT_W), .DEPTH(MAX_COLS*MAX_ROWS)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    flh_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_num), .i_den(r_den), .o_done(w_ddone), .o_quot(w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done <= 1'b0; r_dstart <= 1'b0;
            r_v1 <= 1'b0; r_v2 <= 1'b0;
            r_step <= '0; r_min <= '0; r_max <= '0;
            r_norm <= '0; r_flat <= 1'b0;
        end else begin
            r_done <= 1'b0; r_dstart <= 1'b0;
            r_v2 <= r_v1; r_a2 <= r_a1; r_pos2 <= r_pos1; r_d2 <= w_rdata;
            r_v1 <= 1'b0;
            if (r_v2) begin
                if (w_new < r_lo) r_lo <= w_new;
                if (w_new > r_hi) r_hi <= w_new;
            end
            case (r_state)
                S_IDLE: if (i_start) begin
                    r_norm <= '0; r_flat <= 1'b0;
                    r_a <= i_dir_cos; r_b <= i_dir_sin; r_off <= i_line_offset;
                    r_raddr <= {i_cell_row[ROW_W-1:0], i_cell_col[COL_W-1:0]};
                    r_col <= '0; r_row <= '0; r_clr <= '0;
                    r_lo <= H_MAX; r_hi <= H_MIN;
                    // Row term starts at (0 - hy) * cos, column term at (0 - hx) * sin.
                    r_rowterm <= -32'($signed({1'b0, w_hc[ROW_W:1]})) * 32'(i_dir_cos);
                    r_colterm <= -32'($signed({1'b0, w_wc[COL_W:1]})) * 32'(i_dir_sin);
                    case (i_op)
                        OP_CLEAR: r_state <= S_CLEAR;
                        OP_FAULT: r_state <= S_FAULT;
                        OP_READ: begin
                            if ({1'b0, i_cell_col} < 9'(w_wc) &&
                                {1'b0, i_cell_row} < 9'(w_hc)) begin
                                r_state <= S_RDWAIT;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (ADDR_W+1)'(MAX_COLS*MAX_ROWS-1)) begin
                        r_step <= w_smax; r_min <= w_start; r_max <= w_start;
                        r_state <= S_DONE;
                    end
                end
                S_FAULT: begin
                    r_v1 <= 1'b1;
                    r_a1 <= {r_row[ROW_W-1:0], r_col[COL_W-1:0]};
                    r_pos1 <= (w_side > 0);
                    if (r_col == w_wc - 1'b1) begin
                        r_col <= '0;
                        r_colterm <= -32'($signed({1'b0, w_wc[COL_W:1]})) * 32'(r_b);
                        r_rowterm <= r_rowterm + 32'(r_a);
                        r_row <= r_row + 1'b1;
                        if (r_row == w_hc - 1'b1) r_state <= S_DRAIN;
                    end else begin
                        r_col <= r_col + 1'b1;
                        r_colterm <= r_colterm + 32'(r_b);
                    end
                end
                S_DRAIN: if (!r_v1 && !r_v2) begin
                    r_min <= r_lo; r_max <= r_hi;
                    r_step <= (w_nstep < -17'(w_smax)) ? w_smax : w_nstep[STEP_W-1:0];
                    r_state <= S_DONE;
                end
                S_RDWAIT: begin
                    if (r_v1) begin
                        r_v1 <= 1'b0;
                        if (r_max <= r_min) begin
                            r_flat <= 1'b1; r_state <= S_DONE;
                        end else begin
                            r_num <= w_numr[HGT_W] ? '0 : w_numr;
                            r_den <= (HGT_W+1)'(r_max) - (HGT_W+1)'(r_min);
                            r_dstart <= 1'b1;
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_v1 <= 1'b1;
                    end
                    r_v2 <= 1'b0;
                end
                S_DIV: if (w_ddone) begin
                    r_norm <= w_quot; r_state <= S_DONE;
                end
                S_DONE: begin
                    r_done <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_norm = r_norm;
    assign o_flat = r_flat;

    `include "fault_line_heightmap_top_assert.svh"
    `FLH_ASSERT_IMP(a_we_clear, r_state == S_CLEAR, !r_v2)
    `FLH_ASSERT_NXT(a_done_idle, r_done, r_state == S_IDLE)
    `FLH_ASSERT_IMP(a_flat_norm, r_flat, r_norm == '0)
endmodule

// ----- hdl/fault_line_heightmap_top.sv -----
// Fault-line heightmap top level. A clear writes the whole store, a fault sweeps the
// w by h map, and a read does one RAM read and then a bit-serial divide.
// Throughput: one transaction at a time; the cell sweep, one cell per cycle through
// the cell RAM with one read and one write port, sets the fault and clear rate.
// Reset (synchronous, active low) clears control state, step, min and max and
// restores the registers; the cell RAM is undefined until a clear transaction.
module fault_line_heightmap_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_dir_cos,
    input  logic [15:0] i_dir_sin,
    input  logic [14:0] i_line_offset,
    input  logic [7:0]  i_cell_col,
    input  logic [7:0]  i_cell_row,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_normalized_height,
    output logic        o_flat_map,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);
    import flh_pkg::*;

    logic r_busy, r_ovalid;
    logic [15:0] r_norm;
    logic r_flat;
    logic r_mode;
    logic [DIM_W-1:0] r_w, r_h;
    logic w_done, w_flat, w_acc;
    logic [15:0] w_norm;

    // Accept a new transaction only when the result register is free, so that a
    // finished result can never be overwritten while it waits.
    assign o_ready = !r_busy && !r_ovalid;
    assign w_acc = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    flh_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_acc), .i_op(i_operation),
        .i_dir_cos(i_dir_cos), .i_dir_sin(i_dir_sin), .i_line_offset(i_line_offset),
        .i_cell_col(i_cell_col), .i_cell_row(i_cell_row), .i_mode(r_mode),
        .i_w(r_w), .i_h(r_h), .o_done(w_done), .o_norm(w_norm), .o_flat(w_flat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_ovalid <= 1'b0;
            r_mode <= 1'b0; r_w <= DIM_W'(256); r_h <= DIM_W'(256);
        end else begin
            if (w_acc) r_busy <= 1'b1;
            if (w_done) begin
                r_busy <= 1'b0; r_ovalid <= 1'b1;
                r_norm <= w_norm; r_flat <= w_flat;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MODE:   r_mode <= i_cfg_data[0];
                    CFG_WIDTH:  r_w <= i_cfg_data;
                    CFG_HEIGHT: r_h <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_normalized_height = r_norm;
    assign o_flat_map = r_flat;

    `include "fault_line_heightmap_top_assert.svh"
    `FLH_ASSERT_IMP(a_no_accept_busy, r_busy, !o_ready)
    `FLH_ASSERT_IMP(a_done_free, w_done, !r_ovalid)
    `FLH_ASSERT_NXT(a_hold, o_valid && !i_ready, o_valid && $stable(o_normalized_height))
endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for fault_line_heightmap_top: a scoreboard class predicts
// every result transaction, and plain tasks drive the item and register channels.
// Depends on flh_pkg and the fault_line_heightmap_top RTL.
`timescale 1ns / 100ps

// Keeps its own copy of the cell store, step, extremes and registers. It works out
// the result of each accepted item and compares the block's results in order.
class heightmap_sb;
    int            cells[flh_pkg::MAX_COLS * flh_pkg::MAX_ROWS];
    int            step;
    int            lo_h;
    int            hi_h;
    bit            mountain;
    int            cols_reg;
    int            rows_reg;
    logic [15:0]   want_height[$];
    bit            want_flat[$];

    function void reset_state();
        step = 0;
        lo_h = 0;
        hi_h = 0;
        mountain = 0;
        cols_reg = 256;
        rows_reg = 256;
    endfunction

    function void write_reg(logic [1:0] idx, logic [8:0] data);
        if (idx == flh_pkg::CFG_MODE)
            mountain = data[0];
        else if (idx == flh_pkg::CFG_WIDTH)
            cols_reg = data;
        else if (idx == flh_pkg::CFG_HEIGHT)
            rows_reg = data;
    endfunction

    function int clamp_dim(int v, int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function int sat24(longint v);
        if (v < -8388608)
            return -8388608;
        if (v > 8388607)
            return 8388607;
        return int'(v);
    endfunction

    function bit pending();
        return want_height.size() != 0;
    endfunction

    // Notes one accepted item and works out the result it causes.
    function void note_item(flh_pkg::t_op op, logic [15:0] dcos, logic [15:0] dsin,
                            logic [14:0] offs, logic [7:0] col, logic [7:0] row);
        int          w;
        int          h;
        int          smax;
        int          sdel;
        int          start;
        int          hx;
        int          hy;
        int          lo;
        int          hi;
        int          idx;
        longint      side;
        longint      num;
        longint      den;
        longint      q;
        logic [15:0] res_h;
        bit          res_f;
        w = clamp_dim(cols_reg, flh_pkg::MAX_COLS);
        h = clamp_dim(rows_reg, flh_pkg::MAX_ROWS);
        smax = mountain ? int'(flh_pkg::SMAX_MTN) : int'(flh_pkg::SMAX_PLAIN);
        sdel = mountain ? int'(flh_pkg::SDEL_MTN) : int'(flh_pkg::SDEL_PLAIN);
        start = mountain ? int'(flh_pkg::START_MTN) : int'(flh_pkg::START_PLAIN);
        res_h = '0;
        res_f = 0;
        case (op)
            flh_pkg::OP_CLEAR: begin
                foreach (cells[i])
                    cells[i] = start;
                step = smax;
                lo_h = start;
                hi_h = start;
            end
            flh_pkg::OP_FAULT: begin
                hx = w / 2;
                hy = h / 2;
                lo = 8388607;
                hi = -8388608;
                for (int r = 0; r < h; r++) begin
                    for (int c = 0; c < w; c++) begin
                        side = longint'(r - hy) * longint'($signed(dcos))
                             + longint'(c - hx) * longint'($signed(dsin))
                             + longint'($signed(offs)) * 256;
                        idx = r * flh_pkg::MAX_COLS + c;
                        cells[idx] = sat24(longint'(cells[idx]) + (side > 0 ? step : -step));
                        if (cells[idx] < lo)
                            lo = cells[idx];
                        if (cells[idx] > hi)
                            hi = cells[idx];
                    end
                end
                lo_h = lo;
                hi_h = hi;
                step = step + sdel;
                if (step < -smax)
                    step = smax;
            end
            flh_pkg::OP_READ: begin
                if (col < w && row < h) begin
                    if (hi_h <= lo_h) begin
                        res_f = 1;
                    end else begin
                        num = longint'(cells[row * flh_pkg::MAX_COLS + col]) - lo_h;
                        den = longint'(hi_h) - lo_h;
                        if (num < 0)
                            num = 0;
                        q = (num * 65536) / den;
                        if (q > 65535)
                            q = 65535;
                        res_h = q[15:0];
                    end
                end
            end
            default: ;
        endcase
        want_height.push_back(res_h);
        want_flat.push_back(res_f);
    endfunction

    // Compares one result transaction with the oldest expectation; returns 1 on a match.
    function bit check_result(logic [15:0] got_h, logic got_f, output string msg);
        logic [15:0] eh;
        bit          ef;
        if (want_height.size() == 0) begin
            msg = $sformatf("result with nothing expected: height %0d flat %0d", got_h, got_f);
            return 0;
        end
        eh = want_height.pop_front();
        ef = want_flat.pop_front();
        if (got_h !== eh || got_f !== ef) begin
            msg = $sformatf("height %0d flat %0d, expected height %0d flat %0d",
                            got_h, got_f, eh, ef);
            return 0;
        end
        return 1;
    endfunction
endclass

module tb_top;
    import flh_pkg::*;

    localparam int WATCHDOG_LIMIT = 300000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_operation;
    logic [15:0] i_dir_cos;
    logic [15:0] i_dir_sin;
    logic [14:0] i_line_offset;
    logic [7:0]  i_cell_col;
    logic [7:0]  i_cell_row;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_normalized_height;
    logic        o_flat_map;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [8:0]  i_cfg_data;

    heightmap_sb sb;
    int          errors;
    int          quiet_cycles;
    int          ready_hold;

    fault_line_heightmap_top i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_operation(i_operation),
        .i_dir_cos(i_dir_cos),
        .i_dir_sin(i_dir_sin),
        .i_line_offset(i_line_offset),
        .i_cell_col(i_cell_col),
        .i_cell_row(i_cell_row),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_normalized_height(o_normalized_height),
        .o_flat_map(o_flat_map),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Every mismatch is reported on one line and counted.
    task automatic report(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    // Idle cycles before a transaction; somewhat more than a quarter of the draws give no
    // gap at all, so back-to-back stretches occur as well as gaps.
    function automatic int draw_gap();
        if ($urandom_range(3) == 0)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [15:0] rand_dir();
        int v;
        v = int'($urandom_range(0, 32768)) - 16384;
        return v[15:0];
    endfunction

    // Sends one item. The task is always entered at a rising edge. With no gap the
    // valid stays high straight into the next transaction, so it is never lowered
    // and raised in the same time step.
    task automatic send_item(t_op op, logic [15:0] dcos, logic [15:0] dsin,
                             logic [14:0] offs, logic [7:0] col, logic [7:0] row);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_dir_cos     <= dcos;
        i_dir_sin     <= dsin;
        i_line_offset <= offs;
        i_cell_col    <= col;
        i_cell_row    <= row;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(op, dcos, dsin, offs, col, row);
    endtask

    task automatic send_fault(logic [15:0] dcos, logic [15:0] dsin, logic [14:0] offs);
        send_item(OP_FAULT, dcos, dsin, offs, 8'($urandom), 8'($urandom));
    endtask

    task automatic send_read(logic [7:0] col, logic [7:0] row);
        send_item(OP_READ, rand_dir(), rand_dir(), 15'($urandom), col, row);
    endtask

    // Lets every outstanding result arrive and then a few more cycles, so that the
    // block is idle before the registers are touched.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending()) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // Writes one register; the valid is lowered for a cycle before the task returns.
    task automatic write_reg(logic [1:0] idx, logic [8:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result side: each accepted result transaction is checked, then a fresh stall
    // is drawn. The ready stays high when the draw gives no stall.
    always @(posedge i_clk) begin
        string msg;
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            ready_hold = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (!sb.check_result(o_normalized_height, o_flat_map, msg))
                    report(msg);
                ready_hold = draw_gap();
            end else if (ready_hold > 0) begin
                ready_hold--;
            end
            i_ready <= (ready_hold == 0);
        end
    end

    // The watchdog counts cycles in which no transaction of any channel completes.
    // A fault over the full 256 by 256 map is the longest legitimate silence.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int  cols;
        int  rows;
        int  pick;
        sb = new();
        sb.reset_state();
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_operation   = OP_NONE;
        i_dir_cos     = '0;
        i_dir_sin     = '0;
        i_line_offset = '0;
        i_cell_col    = '0;
        i_cell_row    = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_MODE;
        i_cfg_data    = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on a small 8 by 6 map. The first clear writes the whole
        // store, so no read below can touch a cell that was never written.
        write_reg(CFG_MODE, 9'd0);
        write_reg(CFG_WIDTH, 9'd8);
        write_reg(CFG_HEIGHT, 9'd6);
        send_item(OP_CLEAR, 16'h0000, 16'h0000, 15'h0000, 8'd0, 8'd0);
        send_read(8'd0, 8'd0);                       // flat map straight after a clear
        send_fault(16'h4000, 16'hC000, 15'h4000);    // extreme direction and offset
        send_fault(16'hC000, 16'h4000, 15'h3FFF);
        send_fault(16'h0000, 16'h0000, 15'h0000);    // on the line: every cell goes down
        send_read(8'd0, 8'd0);
        send_read(8'd7, 8'd5);
        send_read(8'd8, 8'd0);                       // one column outside the map
        send_read(8'd255, 8'd255);
        send_item(OP_NONE, 16'hFFFF, 16'hFFFF, 15'h7FFF, 8'hFF, 8'hFF);
        send_fault(16'h4000, 16'h0000, 15'h0000);
        send_read(8'd3, 8'd2);
        send_read(8'd5, 8'd4);
        drain();

        // Growing the map after a fault puts heights outside the tracked range.
        write_reg(CFG_WIDTH, 9'd12);
        send_read(8'd11, 8'd5);
        send_read(8'd10, 8'd0);
        send_read(8'd2, 8'd1);
        drain();

        // Switching to mountain mode after a plain clear leaves the step outside
        // the mode's range; enough faults on a 2 by 2 map make it wrap.
        write_reg(CFG_MODE, 9'd1);
        write_reg(CFG_WIDTH, 9'd2);
        write_reg(CFG_HEIGHT, 9'd2);
        for (int k = 0; k < 24; k++)
            send_fault(rand_dir(), rand_dir(), 15'($urandom));
        send_read(8'd1, 8'd1);
        drain();

        // Sizes beyond the limits saturate: width zero and height 511 give one column
        // of 256 rows, width 511 and height one give a single full row.
        write_reg(CFG_WIDTH, 9'd0);
        write_reg(CFG_HEIGHT, 9'd511);
        send_fault(rand_dir(), rand_dir(), 15'($urandom));
        send_read(8'd0, 8'd255);
        drain();
        write_reg(CFG_WIDTH, 9'd511);
        write_reg(CFG_HEIGHT, 9'd1);
        send_fault(rand_dir(), rand_dir(), 15'($urandom));
        send_read(8'd255, 8'd0);
        drain();

        // One fault over the full 256 by 256 map.
        write_reg(CFG_MODE, 9'd0);
        write_reg(CFG_WIDTH, 9'd256);
        write_reg(CFG_HEIGHT, 9'd256);
        send_fault(rand_dir(), rand_dir(), 15'($urandom));
        send_read(8'($urandom), 8'($urandom));
        drain();

        // Random phases: a fresh setting each time, mostly small maps, sometimes a
        // clear, then a mix of faults and reads with the odd unused operation.
        for (int ph = 0; ph < 5; ph++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                cols = 0;
                rows = $urandom_range(1, 8);
            end else if (pick == 1) begin
                cols = $urandom_range(257, 511);
                rows = 1;
            end else begin
                cols = $urandom_range(1, 16);
                rows = $urandom_range(1, 16);
            end
            write_reg(CFG_MODE, 9'($urandom_range(0, 1)));
            write_reg(CFG_WIDTH, 9'(cols));
            write_reg(CFG_HEIGHT, 9'(rows));
            if ($urandom_range(0, 1) == 0)
                send_item(OP_CLEAR, rand_dir(), rand_dir(), 15'($urandom), 8'($urandom),
                          8'($urandom));
            for (int k = 0; k < 10; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 46)
                    send_fault(rand_dir(), rand_dir(), 15'($urandom));
                else if (pick < 70)
                    send_read(8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)));
                else if (pick < 96)
                    send_read(8'($urandom), 8'($urandom));
                else
                    send_item(OP_NONE, rand_dir(), rand_dir(), 15'($urandom),
                              8'($urandom), 8'($urandom));
            end
            drain();
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/flh_pkg.sv
hdl/flh_ram.sv
hdl/flh_div.sv
hdl/flh_ctrl.sv
hdl/fault_line_heightmap_top.sv
tb/sv/tb_top.sv
